// ===== sv/lcdns_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD nibble sequencer package
// Shared types, codes and constants for the character-LCD 4-bit sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // Request codes on the action port.
    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_CMD    = 3'd1;
    localparam logic [2:0] ACT_CHAR   = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_HOME   = 3'd4;
    localparam logic [2:0] ACT_CURSOR = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FUNCTION_SET = 3'd0;
    localparam logic [2:0] CFG_DISPLAY_CTRL = 3'd1;
    localparam logic [2:0] CFG_ENTRY_MODE   = 3'd2;
    localparam logic [2:0] CFG_PULSE        = 3'd3;
    localparam logic [2:0] CFG_NIBBLE_GAP   = 3'd4;
    localparam logic [2:0] CFG_SLOW_WAIT    = 3'd5;
    localparam logic [2:0] CFG_POWER_ON     = 3'd6;

    // Configuration reset values.
    localparam logic [7:0]  RST_FUNCTION_SET = 8'h28;
    localparam logic [7:0]  RST_DISPLAY_CTRL = 8'h0F;
    localparam logic [7:0]  RST_ENTRY_MODE   = 8'h06;
    localparam logic [7:0]  RST_PULSE        = 8'd10;
    localparam logic [9:0]  RST_NIBBLE_GAP   = 10'd100;
    localparam logic [13:0] RST_SLOW_WAIT    = 14'd2000;
    localparam logic [15:0] RST_POWER_ON     = 16'd40000;

    // LCD command bytes and init constants.
    localparam logic [7:0]  CMD_CLEAR       = 8'h01;
    localparam logic [7:0]  CMD_HOME        = 8'h02;
    localparam logic [7:0]  CURSOR_ROW1     = 8'h80;
    localparam logic [7:0]  CURSOR_ROW2     = 8'hC0;
    localparam logic [3:0]  INIT_NIB_A      = 4'h3;
    localparam logic [3:0]  INIT_NIB_B      = 4'h2;
    localparam logic [15:0] INIT_WAIT_LONG  = 16'd5000;
    localparam logic [15:0] INIT_WAIT_SHORT = 16'd150;
    localparam logic [5:0]  MAX_COLUMN      = 6'd40;

    // Sequencer step numbering.
    localparam int          STEP_W         = 4;
    localparam logic [3:0]  INIT_LAST_STEP = 4'd11;
    localparam logic [3:0]  INIT_CLR_LO    = 4'd9;
    localparam logic [3:0]  BYTE_LAST_STEP = 4'd1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_CMD,
        KIND_CHAR,
        KIND_SLOW
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } desc_t;

    typedef struct packed {
        logic [7:0]  function_set;
        logic [7:0]  display_ctrl;
        logic [7:0]  entry_mode;
        logic [7:0]  pulse_us;
        logic [9:0]  gap_us;
        logic [13:0] slow_us;
        logic [15:0] power_on_us;
    } cfg_t;

endpackage

// ===== sv/lcdns_front.sv =====
// ----------------------------------------------------------------------------
// LCD nibble sequencer front end
// Checks each request and turns it into a queue word for the back end.
// ----------------------------------------------------------------------------
module lcdns_front (
    input  logic               accept,
    input  logic [2:0]         action,
    input  logic [7:0]         byte_value,
    input  logic [1:0]         row,
    input  logic [5:0]         column,
    output logic               push,
    output lcdns_pkg::desc_t   desc
);
    import lcdns_pkg::*;

    logic       has_work;
    logic       col_ok;
    logic [5:0] col_m1;

    assign col_ok = column inside {[6'd1:MAX_COLUMN]};
    assign col_m1 = column - 6'd1;

    always_comb
    begin
        has_work   = 1'b1;
        desc.kind  = KIND_CMD;
        desc.value = byte_value;
        case (action)
            ACT_INIT:
            begin
                desc.kind  = KIND_INIT;
                desc.value = 8'h00;
            end
            ACT_CMD:
            begin
                desc.kind = KIND_CMD;
            end
            ACT_CHAR:
            begin
                desc.kind = KIND_CHAR;
            end
            ACT_CLEAR:
            begin
                desc.kind  = KIND_SLOW;
                desc.value = CMD_CLEAR;
            end
            ACT_HOME:
            begin
                desc.kind  = KIND_SLOW;
                desc.value = CMD_HOME;
            end
            ACT_CURSOR:
            begin
                desc.kind  = KIND_CMD;
                desc.value = ((row == 2'd2) ? CURSOR_ROW2 : CURSOR_ROW1) | {2'b00, col_m1};
                // An off-screen position produces nothing at all.
                has_work   = col_ok && (row inside {2'd1, 2'd2});
            end
            default:
            begin
                has_work = 1'b0;
            end
        endcase
    end

    assign push = accept && has_work;

endmodule

// ===== sv/lcdns_queue.sv =====
// ----------------------------------------------------------------------------
// LCD nibble sequencer request queue
// Small FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module lcdns_queue #(
    parameter int Depth = lcdns_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcdns_pkg::desc_t   push_desc,
    input  logic               pop,
    output lcdns_pkg::desc_t   head,
    output logic               empty,
    output logic               full
);
    import lcdns_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    desc_t           mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FullCnt);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== sv/lcdns_back.sv =====
// ----------------------------------------------------------------------------
// LCD nibble sequencer back end
// Steps through the nibbles of one request per queue word, one per cycle.
// ----------------------------------------------------------------------------
module lcdns_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lcdns_pkg::cfg_t    cfg,
    input  lcdns_pkg::desc_t   head,
    input  logic               empty,
    output logic               pop,
    output logic               result_valid,
    output logic               reg_select,
    output logic [3:0]         nibble,
    output logic [15:0]        pre_wait_us,
    output logic [7:0]         pulse_us,
    output logic [15:0]        post_wait_us,
    output logic               last
);
    import lcdns_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t            state_reg;
    desc_t             desc_reg;
    logic [STEP_W-1:0] step_reg;

    logic              valid_reg;
    logic              rs_reg;
    logic [3:0]        nib_reg;
    logic [15:0]       pre_reg;
    logic [7:0]        pulse_reg;
    logic [15:0]       post_reg;
    logic              last_reg;

    logic [7:0]        cur_byte;
    logic [3:0]        cur_nib;
    logic [15:0]       cur_pre;
    logic [15:0]       cur_post;
    logic              cur_last;
    logic              cur_slow;
    logic              is_init;
    logic              finishing;

    assign is_init = (desc_reg.kind == KIND_INIT);

    always_comb
    begin
        case (step_reg[3:1])
            3'd2:    cur_byte = is_init ? cfg.function_set : desc_reg.value;
            3'd3:    cur_byte = is_init ? cfg.display_ctrl : desc_reg.value;
            3'd4:    cur_byte = is_init ? CMD_CLEAR : desc_reg.value;
            3'd5:    cur_byte = is_init ? cfg.entry_mode : desc_reg.value;
            default: cur_byte = desc_reg.value;
        endcase

        if (is_init && (step_reg < 4'd3))
        begin
            cur_nib = INIT_NIB_A;
        end
        else if (is_init && (step_reg == 4'd3))
        begin
            cur_nib = INIT_NIB_B;
        end
        else
        begin
            cur_nib = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        end

        cur_pre = '0;
        if (is_init)
        begin
            case (step_reg)
                4'd0:    cur_pre = cfg.power_on_us;
                4'd1:    cur_pre = INIT_WAIT_LONG;
                4'd2:    cur_pre = INIT_WAIT_SHORT;
                default: cur_pre = '0;
            endcase
        end

        cur_last = is_init ? (step_reg == INIT_LAST_STEP) : (step_reg == BYTE_LAST_STEP);
        cur_slow = is_init ? (step_reg == INIT_CLR_LO)
                           : ((desc_reg.kind == KIND_SLOW) && (step_reg == BYTE_LAST_STEP));

        // The widest sum is well below 16 bits, so it never needs to saturate.
        cur_post = {6'b0, cfg.gap_us} + (cur_slow ? {2'b0, cfg.slow_us} : 16'd0);
    end

    assign finishing = (state_reg == ST_SEND) && cur_last;
    assign pop       = !empty && ((state_reg == ST_IDLE) || finishing);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            rs_reg    <= 1'b0;
            nib_reg   <= '0;
            pre_reg   <= '0;
            pulse_reg <= '0;
            post_reg  <= '0;
            desc_reg  <= '0;
        end
        else
        begin
            valid_reg <= (state_reg == ST_SEND);
            if (state_reg == ST_SEND)
            begin
                rs_reg    <= (desc_reg.kind == KIND_CHAR);
                nib_reg   <= cur_nib;
                pre_reg   <= cur_pre;
                pulse_reg <= cfg.pulse_us;
                post_reg  <= cur_post;
                last_reg  <= cur_last;
            end

            if (pop)
            begin
                state_reg <= ST_SEND;
                desc_reg  <= head;
                step_reg  <= '0;
            end
            else if (finishing)
            begin
                state_reg <= ST_IDLE;
            end
            else if (state_reg == ST_SEND)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign result_valid = valid_reg;
    assign reg_select   = rs_reg;
    assign nibble       = nib_reg;
    assign pre_wait_us  = pre_reg;
    assign pulse_us     = pulse_reg;
    assign post_wait_us = post_reg;
    assign last         = last_reg;

endmodule

// ===== sv/char_lcd_nibble_sequencer.sv =====
// From an idle sequencer, an accepted request goes through the queue, the back-end send
// state and the output register before its first nibble is strobed. Throughput: one nibble
// per cycle from the back-end sequencer. busy rises while the request queue is full.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset clears the queue and the sequencer and restores every configuration default.
// ----------------------------------------------------------------------------
// Character-LCD nibble sequencer
// Expands LCD requests into timed 4-bit nibble transfers with enable timing.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
    parameter int QueueDepth = lcdns_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [7:0]  byte_value,
    input  logic [1:0]  row,
    input  logic [5:0]  column,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [15:0] pre_wait_us,
    output logic [7:0]  pulse_us,
    output logic [15:0] post_wait_us,
    output logic        last
);
    import lcdns_pkg::*;

    cfg_t  cfg_reg;
    desc_t front_desc;
    desc_t head;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;

    assign cfg_ready = 1'b1;
    assign busy      = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_set <= RST_FUNCTION_SET;
            cfg_reg.display_ctrl <= RST_DISPLAY_CTRL;
            cfg_reg.entry_mode   <= RST_ENTRY_MODE;
            cfg_reg.pulse_us     <= RST_PULSE;
            cfg_reg.gap_us       <= RST_NIBBLE_GAP;
            cfg_reg.slow_us      <= RST_SLOW_WAIT;
            cfg_reg.power_on_us  <= RST_POWER_ON;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FUNCTION_SET: cfg_reg.function_set <= cfg_data[7:0];
                CFG_DISPLAY_CTRL: cfg_reg.display_ctrl <= cfg_data[7:0];
                CFG_ENTRY_MODE:   cfg_reg.entry_mode   <= cfg_data[7:0];
                CFG_PULSE:        cfg_reg.pulse_us     <= cfg_data[7:0];
                CFG_NIBBLE_GAP:   cfg_reg.gap_us       <= cfg_data[9:0];
                CFG_SLOW_WAIT:    cfg_reg.slow_us      <= cfg_data[13:0];
                CFG_POWER_ON:     cfg_reg.power_on_us  <= cfg_data;
                default:          ;
            endcase
        end
    end

    lcdns_front u_front (
        .accept     (start && !busy),
        .action     (action),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .push       (push),
        .desc       (front_desc)
    );

    lcdns_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (front_desc),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    lcdns_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .reg_select   (reg_select),
        .nibble       (nibble),
        .pre_wait_us  (pre_wait_us),
        .pulse_us     (pulse_us),
        .post_wait_us (post_wait_us),
        .last         (last)
    );

endmodule

// ===== sv/lcdns_checker.sv =====
// ----------------------------------------------------------------------------
// LCD nibble sequencer port checker
// Watches the top-level ports for sequencing and reset behavior.
// ----------------------------------------------------------------------------
module lcdns_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        result_valid,
    input logic        reg_select,
    input logic [15:0] pre_wait_us,
    input logic        last
);

    // Reset leaves no word pending and the queue open.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> (!result_valid && !busy))
        else $error("output or busy active right after reset");

    // The nibbles of one request come out in consecutive cycles.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside a request's nibble run");

    // Character data never carries a pre-enable wait.
    a_char_no_pre: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && reg_select) |-> (pre_wait_us == 16'd0))
        else $error("data nibble with a pre-enable wait");

    // Pre-enable waits only occur early in init, a command run that is not ending.
    a_pre_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (pre_wait_us != 16'd0)) |-> (!reg_select && !last))
        else $error("pre-enable wait outside the init preamble");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_checker (.*);

// ===== verif/char_lcd_nibble_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character-LCD nibble sequencer testbench
// Drives LCD requests and register writes, predicts every nibble word the
// sequencer should strobe, and compares each strobed word field by field.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_tb;

    import lcdns_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 470;
    localparam int MAX_PRINTS    = 30;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic [15:0] pre;
        logic [7:0]  pulse;
        logic [15:0] post;
        logic        last;
    } nibble_word_t;

    class lcd_scoreboard;
        cfg_t         regs;
        nibble_word_t expected_words[$];
        int           mismatches;
        int           words_checked;
        int           requests_seen;

        function new();
            regs.function_set = RST_FUNCTION_SET;
            regs.display_ctrl = RST_DISPLAY_CTRL;
            regs.entry_mode   = RST_ENTRY_MODE;
            regs.pulse_us     = RST_PULSE;
            regs.gap_us       = RST_NIBBLE_GAP;
            regs.slow_us      = RST_SLOW_WAIT;
            regs.power_on_us  = RST_POWER_ON;
            mismatches    = 0;
            words_checked = 0;
            requests_seen = 0;
        endfunction

        function void apply_setting(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_FUNCTION_SET: regs.function_set = data[7:0];
                CFG_DISPLAY_CTRL: regs.display_ctrl = data[7:0];
                CFG_ENTRY_MODE:   regs.entry_mode   = data[7:0];
                CFG_PULSE:        regs.pulse_us     = data[7:0];
                CFG_NIBBLE_GAP:   regs.gap_us       = data[9:0];
                CFG_SLOW_WAIT:    regs.slow_us      = data[13:0];
                CFG_POWER_ON:     regs.power_on_us  = data;
                default: ;
            endcase
        endfunction

        function void push_nibble(logic rs, logic [3:0] nib, logic [15:0] pre,
                                  logic [13:0] extra);
            logic [16:0]  sum;
            nibble_word_t w;
            sum     = {7'd0, regs.gap_us} + {3'd0, extra};
            w.rs    = rs;
            w.nib   = nib;
            w.pre   = pre;
            w.pulse = regs.pulse_us;
            w.post  = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
            w.last  = 1'b0;
            expected_words.push_back(w);
        endfunction

        // A byte goes out as two nibbles, high half first; only the second
        // one carries the extra wait of a slow command.
        function void push_byte(logic rs, logic [7:0] b, logic [13:0] extra);
            push_nibble(rs, b[7:4], 16'd0, 14'd0);
            push_nibble(rs, b[3:0], 16'd0, extra);
        endfunction

        function void note_request(logic [2:0] act, logic [7:0] b, logic [1:0] r,
                                   logic [5:0] c);
            int          before_size;
            logic [7:0]  col_off;
            before_size = expected_words.size();
            col_off     = {2'b00, c - 6'd1};
            requests_seen++;
            case (act)
                ACT_INIT:
                begin
                    push_nibble(1'b0, INIT_NIB_A, regs.power_on_us, 14'd0);
                    push_nibble(1'b0, INIT_NIB_A, INIT_WAIT_LONG, 14'd0);
                    push_nibble(1'b0, INIT_NIB_A, INIT_WAIT_SHORT, 14'd0);
                    push_nibble(1'b0, INIT_NIB_B, 16'd0, 14'd0);
                    push_byte(1'b0, regs.function_set, 14'd0);
                    push_byte(1'b0, regs.display_ctrl, 14'd0);
                    push_byte(1'b0, CMD_CLEAR, regs.slow_us);
                    push_byte(1'b0, regs.entry_mode, 14'd0);
                end
                ACT_CMD:    push_byte(1'b0, b, 14'd0);
                ACT_CHAR:   push_byte(1'b1, b, 14'd0);
                ACT_CLEAR:  push_byte(1'b0, CMD_CLEAR, regs.slow_us);
                ACT_HOME:   push_byte(1'b0, CMD_HOME, regs.slow_us);
                ACT_CURSOR:
                begin
                    if (c >= 6'd1 && c <= MAX_COLUMN)
                    begin
                        if (r == 2'd1)
                            push_byte(1'b0, CURSOR_ROW1 | col_off, 14'd0);
                        else if (r == 2'd2)
                            push_byte(1'b0, CURSOR_ROW2 | col_off, 14'd0);
                    end
                end
                default: ;
            endcase
            if (expected_words.size() > before_size)
                expected_words[expected_words.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] MISMATCH word %0d: %s", $realtime, words_checked, what);
        endtask

        task compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
                report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
        endtask

        task check_result(nibble_word_t got);
            nibble_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch("word strobed with nothing expected");
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("reg_select", want.rs, got.rs);
                compare_field("nibble", want.nib, got.nib);
                compare_field("pre_wait_us", want.pre, got.pre);
                compare_field("pulse_us", want.pulse, got.pulse);
                compare_field("post_wait_us", want.post, got.post);
                compare_field("last", want.last, got.last);
            end
            words_checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [5:0]  column;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] pre_wait_us;
    logic [7:0]  pulse_us;
    logic [15:0] post_wait_us;
    logic        last;

    lcd_scoreboard sb = new();
    int            reg_writes = 0;
    int            quiet_cycles = 0;
    bit            allow_gaps = 1'b1;

    char_lcd_nibble_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .byte_value   (byte_value),
        .row          (row),
        .column       (column),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .reg_select   (reg_select),
        .nibble       (nibble),
        .pre_wait_us  (pre_wait_us),
        .pulse_us     (pulse_us),
        .post_wait_us (post_wait_us),
        .last         (last)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitors sample at the edge, so they see the values that the edge accepts.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request(action, byte_value, row, column);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result('{reg_select, nibble, pre_wait_us, pulse_us,
                              post_wait_us, last});
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Every task below is entered right after a rising edge.
    task automatic send_request(logic [2:0] act, logic [7:0] b, logic [1:0] r,
                                logic [5:0] c);
        start      <= 1'b1;
        action     <= act;
        byte_value <= b;
        row        <= r;
        column     <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (allow_gaps && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 7));
    endtask

    // Waits until every predicted word has come; the settle time covers
    // requests still in flight that produce no words.
    task automatic drain(bit settle);
        start <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_setting(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [15:0] data;
        for (int i = CFG_FUNCTION_SET; i <= CFG_POWER_ON; i++)
        begin
            case ($urandom_range(0, 5))
                0:       data = 16'h0000;
                1:       data = 16'hFFFF;
                default: data = 16'($urandom_range(0, 65535));
            endcase
            program_reg(3'(i), data);
        end
    endtask

    task automatic random_request(output bit productive);
        int          pick;
        logic [2:0]  act;
        logic [1:0]  r;
        logic [5:0]  c;
        pick = $urandom_range(0, 99);
        r    = 2'($urandom_range(0, 3));
        c    = 6'($urandom_range(0, 63));
        if (pick < 6)
            act = ACT_INIT;
        else if (pick < 26)
            act = ACT_CMD;
        else if (pick < 50)
            act = ACT_CHAR;
        else if (pick < 57)
            act = ACT_CLEAR;
        else if (pick < 64)
            act = ACT_HOME;
        else if (pick < 96)
        begin
            act = ACT_CURSOR;
            // Mostly legal positions, with some outside the display.
            if (pick < 90)
            begin
                r = 2'($urandom_range(1, 2));
                c = 6'($urandom_range(1, MAX_COLUMN));
            end
        end
        else
            act = 3'($urandom_range(6, 7));
        productive = (act <= ACT_CURSOR) &&
                     (act != ACT_CURSOR || ((r == 2'd1 || r == 2'd2) &&
                                            c >= 6'd1 && c <= MAX_COLUMN));
        send_request(act, 8'($urandom_range(0, 255)), r, c);
        maybe_gap();
    endtask

    initial
    begin
        bit productive;
        int done_items;
        int phase_items;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = '0;
        byte_value = '0;
        row        = '0;
        column     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the reset settings.
        send_request(ACT_INIT, 8'h00, 2'd0, 6'd0);
        send_request(ACT_CMD, 8'h00, 2'd0, 6'd0);
        send_request(ACT_CMD, 8'hFF, 2'd3, 6'd63);
        send_request(ACT_CHAR, 8'hA5, 2'd0, 6'd0);
        send_request(ACT_CHAR, 8'h5A, 2'd0, 6'd0);
        send_request(ACT_CLEAR, 8'h00, 2'd0, 6'd0);
        send_request(ACT_HOME, 8'h00, 2'd0, 6'd0);
        send_request(ACT_CURSOR, 8'h00, 2'd1, 6'd1);
        send_request(ACT_CURSOR, 8'h00, 2'd2, 6'd40);
        send_request(ACT_CURSOR, 8'h00, 2'd1, 6'd40);
        send_request(ACT_CURSOR, 8'h00, 2'd2, 6'd1);
        // Positions off the display and unknown actions give nothing.
        send_request(ACT_CURSOR, 8'h00, 2'd0, 6'd5);
        send_request(ACT_CURSOR, 8'h00, 2'd3, 6'd5);
        send_request(ACT_CURSOR, 8'h00, 2'd1, 6'd0);
        send_request(ACT_CURSOR, 8'h00, 2'd2, 6'd41);
        send_request(ACT_CURSOR, 8'h00, 2'd1, 6'd63);
        send_request(3'd6, 8'hFF, 2'd3, 6'd63);
        send_request(3'd7, 8'h00, 2'd0, 6'd0);
        drain(1'b1);

        // Every register at its top value, plus a write past the register list.
        program_reg(CFG_FUNCTION_SET, 16'h00FF);
        program_reg(CFG_DISPLAY_CTRL, 16'h00FF);
        program_reg(CFG_ENTRY_MODE, 16'h00FF);
        program_reg(CFG_PULSE, 16'h00FF);
        program_reg(CFG_NIBBLE_GAP, 16'h03FF);
        program_reg(CFG_SLOW_WAIT, 16'h3FFF);
        program_reg(CFG_POWER_ON, 16'hFFFF);
        program_reg(3'd7, 16'hFFFF);
        send_request(ACT_INIT, 8'h00, 2'd0, 6'd0);
        send_request(ACT_CLEAR, 8'h00, 2'd0, 6'd0);
        send_request(ACT_HOME, 8'h00, 2'd0, 6'd0);
        send_request(ACT_CHAR, 8'hFF, 2'd0, 6'd0);
        drain(1'b1);

        // Every register at zero, including a zero-width enable pulse.
        for (int i = CFG_FUNCTION_SET; i <= CFG_POWER_ON; i++)
            program_reg(3'(i), 16'h0000);
        send_request(ACT_INIT, 8'h00, 2'd0, 6'd0);
        send_request(ACT_HOME, 8'h00, 2'd0, 6'd0);
        drain(1'b1);

        // Random phases, each under its own settings; the last one runs flat out.
        done_items = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            random_settings();
            allow_gaps  = (phase < 4);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 5)
            begin
                random_request(productive);
                if (productive)
                    phase_items++;
                if (phase == 1 && phase_items == 40 && productive)
                    drain(1'b0);
            end
            done_items += phase_items;
            drain(1'b1);
        end

        $display("Covered %0d requests (%0d random) and %0d nibble words",
                 sb.requests_seen, done_items, sb.words_checked);
        $display("Register writes: %0d over several settings; mismatches: %0d",
                 reg_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lcdns_pkg.sv
sv/lcdns_front.sv
sv/lcdns_queue.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_sequencer.sv
sv/lcdns_checker.sv
verif/char_lcd_nibble_sequencer_tb.sv
